/* hdl/adsf_pkg.sv */
// Shared types and constants for the advertising service-data finder.
package adsf_pkg;

    localparam logic [7:0]  MAX_PAYLOAD_LEN    = 8'd255;
    localparam logic [7:0]  AD_TYPE_SVC_DATA16 = 8'h16;
    localparam logic [15:0] UUID_RESET         = 16'hFE95;
    localparam int          QUEUE_DEPTH        = 4;

    typedef enum logic [2:0] {
        PH_DONE,
        PH_LEN,
        PH_TYPE,
        PH_ULO,
        PH_UHI,
        PH_SKIP,
        PH_DATA
    } phase_t;

    // ENT_LAST expands to the last data word followed by a found verdict
    typedef enum logic [1:0] {
        ENT_DATA,
        ENT_LAST,
        ENT_VERDICT
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t kind;
        logic [7:0]  dbyte;
        logic        found;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* hdl/adsf_front.sv */
// Front end: walks the length/type/data structures and classifies each byte.
module adsf_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            start_req,
    input  logic [7:0]      payload_len,
    input  logic [7:0]      payload_byte,
    input  logic [15:0]     uuid,
    output logic            push,
    output adsf_pkg::entry_t push_entry
);
    import adsf_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] pos_reg, pos_next;
    logic [7:0] left_reg, left_next;
    logic [7:0] ulo_reg, ulo_next;
    logic [7:0] hlen_reg, hlen_next;

    phase_t     phase_eff;
    logic [7:0] pos_eff;
    logic [7:0] left_eff;
    logic [7:0] ulo_eff;
    logic [7:0] hlen_eff;
    logic [7:0] len_sat;
    logic [7:0] left_dec;
    logic       entry_end;
    logic       adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            pos_reg   <= '0;
            left_reg  <= '0;
            ulo_reg   <= '0;
            hlen_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
            ulo_reg   <= ulo_next;
            hlen_reg  <= hlen_next;
        end
    end

    always_comb
    begin
        len_sat   = (payload_len > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : payload_len;
        phase_eff = start_req ? PH_LEN : phase_reg;
        pos_eff   = start_req ? 8'd0 : pos_reg;
        left_eff  = start_req ? 8'd0 : left_reg;
        ulo_eff   = start_req ? 8'd0 : ulo_reg;
        hlen_eff  = start_req ? len_sat : hlen_reg;
        left_dec  = left_eff - 8'd1;

        phase_next = phase_eff;
        pos_next   = pos_eff;
        left_next  = left_eff;
        ulo_next   = ulo_eff;
        hlen_next  = hlen_eff;
        push       = 1'b0;
        push_entry = '{kind: ENT_VERDICT, dbyte: 8'd0, found: 1'b0};
        entry_end  = 1'b0;
        adv        = 1'b0;

        if (phase_eff == PH_DONE)
        begin
            phase_next = PH_DONE;
        end
        else if (pos_eff >= hlen_eff)
        begin
            push       = 1'b1;
            phase_next = PH_DONE;
        end
        else
        begin
            case (phase_eff)
                PH_LEN:
                begin
                    if (payload_byte == 8'd0 ||
                        ({1'b0, pos_eff} + 9'd1 + {1'b0, payload_byte}) > {1'b0, hlen_eff})
                    begin
                        push       = 1'b1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        left_next  = payload_byte;
                        phase_next = PH_TYPE;
                        adv        = 1'b1;
                    end
                end
                PH_TYPE:
                begin
                    left_next = left_dec;
                    adv       = 1'b1;
                    if (payload_byte == AD_TYPE_SVC_DATA16 && left_dec >= 8'd2)
                        phase_next = PH_ULO;
                    else if (left_dec != 8'd0)
                        phase_next = PH_SKIP;
                    else
                        entry_end = 1'b1;
                end
                PH_ULO:
                begin
                    ulo_next   = payload_byte;
                    left_next  = left_dec;
                    phase_next = PH_UHI;
                    adv        = 1'b1;
                end
                PH_UHI:
                begin
                    left_next = left_dec;
                    if ({payload_byte, ulo_eff} == uuid)
                    begin
                        if (left_dec == 8'd0)
                        begin
                            // matched entry with no data: verdict only
                            push             = 1'b1;
                            push_entry.found = 1'b1;
                            phase_next       = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                            adv        = 1'b1;
                        end
                    end
                    else
                    begin
                        adv = 1'b1;
                        if (left_dec != 8'd0)
                            phase_next = PH_SKIP;
                        else
                            entry_end = 1'b1;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_dec;
                    adv       = 1'b1;
                    if (left_dec == 8'd0)
                        entry_end = 1'b1;
                end
                PH_DATA:
                begin
                    left_next        = left_dec;
                    push             = 1'b1;
                    push_entry.dbyte = payload_byte;
                    if (left_dec == 8'd0)
                    begin
                        push_entry.kind = ENT_LAST;
                        phase_next      = PH_DONE;
                    end
                    else
                    begin
                        push_entry.kind = ENT_DATA;
                        adv             = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            if (entry_end)
            begin
                // end of payload reached on an entry boundary: not found
                if (({1'b0, pos_eff} + 9'd1) >= {1'b0, hlen_eff})
                begin
                    push       = 1'b1;
                    phase_next = PH_DONE;
                    adv        = 1'b0;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end

            if (adv)
                pos_next = pos_eff + 8'd1;
        end
    end

endmodule

/* hdl/adsf_queue.sv */
// Short word queue between the parser and the output stage.
module adsf_queue
#(
    parameter int DEPTH = adsf_pkg::QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  adsf_pkg::entry_t       push_entry,
    input  logic                   pop,
    output adsf_pkg::entry_t       pop_entry,
    output adsf_pkg::queue_status_t status
);
    import adsf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    assign pop_entry    = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign status.empty = (cnt_reg == '0);

endmodule

/* hdl/adsf_back.sv */
// Back end: expands queued words into result words behind an output register.
module adsf_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  adsf_pkg::queue_status_t status,
    input  adsf_pkg::entry_t        pop_entry,
    output logic                    pop,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic                    is_data,
    output logic [7:0]              data_byte,
    output logic                    last_data,
    output logic                    found
);
    import adsf_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic       pend_reg, pend_next;
    logic       is_data_reg, is_data_next;
    logic [7:0] data_byte_reg, data_byte_next;
    logic       last_data_reg, last_data_next;
    logic       found_reg, found_next;
    logic       load;

    always_comb
    begin
        load           = !out_valid_reg || !out_stall;
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        is_data_next   = is_data_reg;
        data_byte_next = data_byte_reg;
        last_data_next = last_data_reg;
        found_next     = found_reg;

        if (load)
        begin
            if (pend_reg)
            begin
                // found verdict behind the last data word
                out_valid_next = 1'b1;
                pend_next      = 1'b0;
                is_data_next   = 1'b0;
                data_byte_next = 8'd0;
                last_data_next = 1'b0;
                found_next     = 1'b1;
            end
            else if (!status.empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                case (pop_entry.kind)
                    ENT_DATA:
                    begin
                        is_data_next   = 1'b1;
                        data_byte_next = pop_entry.dbyte;
                        last_data_next = 1'b0;
                        found_next     = 1'b0;
                    end
                    ENT_LAST:
                    begin
                        is_data_next   = 1'b1;
                        data_byte_next = pop_entry.dbyte;
                        last_data_next = 1'b1;
                        found_next     = 1'b0;
                        pend_next      = 1'b1;
                    end
                    default:
                    begin
                        is_data_next   = 1'b0;
                        data_byte_next = 8'd0;
                        last_data_next = 1'b0;
                        found_next     = pop_entry.found;
                    end
                endcase
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_data_reg   <= is_data_next;
        data_byte_reg <= data_byte_next;
        last_data_reg <= last_data_next;
        found_reg     <= found_next;
    end

    assign out_valid = out_valid_reg;
    assign is_data   = is_data_reg;
    assign data_byte = data_byte_reg;
    assign last_data = last_data_reg;
    assign found     = found_reg;

endmodule

/* hdl/adv_service_data_finder.sv */
// Top level of the advertising service-data finder.
//
// Input channel (in_valid / in_stall): one payload byte per word with its
// start mark and the payload length. A byte is taken at an edge with
// in_valid high and in_stall low; one byte per cycle is sustained while in_stall stays low.
// Output channel (out_valid / out_stall): service data bytes after the
// matching UUID, the last one marked, then one verdict word (found set or
// clear). A payload yields at most one verdict; bytes after it are dropped
// until the next start mark, and a start mark mid payload drops the search
// without a verdict.
// Path: a result word is written into the queue when its byte is taken,
// then into the output register; a found verdict trails its last data byte.
// The parser and the output register are parted by a QUEUE_DEPTH-word
// queue; in_stall rises only when that queue is full, so an output stall
// holds the current word and backs up into the input after QUEUE_DEPTH
// more words.
// Configuration: wanted_uuid is written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high. Write only while idle.
// Reset: clears the queue and output, the parser waits for a start mark,
// wanted_uuid returns to 0xFE95.
module adv_service_data_finder
#(
    parameter int QUEUE_DEPTH = adsf_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] wanted_uuid,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_req,
    input  logic [7:0]  payload_len,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_data,
    output logic [7:0]  data_byte,
    output logic        last_data,
    output logic        found
);
    import adsf_pkg::*;

    logic [15:0]   wanted_uuid_reg;
    logic          accept;
    logic          push;
    entry_t        push_entry;
    logic          pop;
    entry_t        pop_entry;
    queue_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wanted_uuid_reg <= UUID_RESET;
        else if (cfg_valid && cfg_ready)
            wanted_uuid_reg <= wanted_uuid;
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = status.full;
    assign accept    = in_valid && !in_stall;

    adsf_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .start_req    (start_req),
        .payload_len  (payload_len),
        .payload_byte (payload_byte),
        .uuid         (wanted_uuid_reg),
        .push         (push),
        .push_entry   (push_entry)
    );

    adsf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push && accept),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (status)
    );

    adsf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .is_data   (is_data),
        .data_byte (data_byte),
        .last_data (last_data),
        .found     (found)
    );

endmodule

/* hdl/adsf_checker.sv */
// Port-level checks for the service-data finder, bound to the top level.
module adsf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_data,
    input logic [7:0] data_byte,
    input logic       last_data,
    input logic       found
);

    // a last data word that leaves unstalled is always followed at once by a found verdict
    a_last_then_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && is_data && last_data
        |=> out_valid && !is_data && found)
        else $error("last data word not followed by found verdict");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |-> data_byte == 8'd0 && !last_data)
        else $error("verdict word carries data");

    a_data_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_data |-> !found)
        else $error("data word carries found");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall
        |=> out_valid && $stable(data_byte) && $stable(is_data) && $stable(found))
        else $error("output word changed while stalled");

endmodule

bind adv_service_data_finder adsf_checker u_adsf_checker (.*);
